FILE: hdl/wshp_pkg.sv
// Shared types, constants and helpers of the WebSocket frame header parser.
// No dependencies; every other file of the block takes names from here.
package wshp_pkg;

	localparam int unsigned PlenW = 63;
	localparam int unsigned AccW = 64;

	localparam logic [PlenW-1:0] MAX_PAYLOAD_RST = 63'd4096;

	localparam logic [6:0] LEN_CODE_16 = 7'd126;
	localparam logic [6:0] LEN_CODE_64 = 7'd127;
	localparam logic [6:0] CTRL_MAX_LEN = 7'd125;

	localparam logic [3:0] HDR_LEN_SHORT = 4'd2;
	localparam logic [3:0] HDR_LEN_MID = 4'd4;
	localparam logic [3:0] HDR_LEN_LONG = 4'd10;

	localparam logic [3:0] CNT_IDLE = 4'd0;
	localparam logic [3:0] CNT_GOT_B0 = 4'd1;

	localparam logic [3:0] OP_BINARY = 4'h2;
	localparam logic [3:0] OP_CLOSE = 4'h8;
	localparam logic [3:0] OP_PONG = 4'hA;

	typedef enum logic [1:0] {
		ST_OK = 2'd0,
		ST_PROTO_ERR = 2'd1,
		ST_TOO_LARGE = 2'd2
	} status_t;

	// completed header, handed from capture to check
	typedef struct packed {
		logic [7:0] b0;
		logic [7:0] b1;
		logic [AccW-1:0] accum;
	} hdr_t;

	typedef struct packed {
		status_t status;
		logic fin_flag;
		logic [3:0] frame_opcode;
		logic [PlenW-1:0] payload_length;
		logic [3:0] header_length;
	} result_t;

	// header bytes needed, from byte 1
	function automatic logic [3:0] needed_bytes(input logic [7:0] b1);
		logic [3:0] n;
		if (b1[6:0] == LEN_CODE_16) begin
			n = HDR_LEN_MID;
		end else if (b1[6:0] == LEN_CODE_64) begin
			n = HDR_LEN_LONG;
		end else begin
			n = HDR_LEN_SHORT;
		end
		return n;
	endfunction

endpackage

FILE: hdl/wshp_if.sv
// Valid/ready channel interfaces for header bytes and parse results.
// Depends on wshp_pkg for the payload widths.
interface wshp_in_if;
	logic valid;
	logic ready;
	logic [7:0] data_byte;
	logic header_start;

	modport source(output valid, output data_byte, output header_start, input ready);
	modport sink(input valid, input data_byte, input header_start, output ready);
endinterface

interface wshp_out_if;
	logic valid;
	logic ready;
	logic [1:0] status;
	logic fin_flag;
	logic [3:0] frame_opcode;
	logic [wshp_pkg::PlenW-1:0] payload_length;
	logic [3:0] header_length;

	modport source(output valid, output status, output fin_flag, output frame_opcode,
		output payload_length, output header_length, input ready);
	modport sink(input valid, input status, input fin_flag, input frame_opcode,
		input payload_length, input header_length, output ready);
endinterface

FILE: hdl/wshp_capture.sv
// Byte capture: byte counter, bytes 0/1, length accumulator, completed-header register.
// Depends on wshp_pkg.
module wshp_capture (
	input  logic clk,
	input  logic arst_n,
	input  logic accept,
	input  logic [7:0] data_byte,
	input  logic header_start,
	input  logic advance,
	output logic hdr_valid,
	output wshp_pkg::hdr_t hdr
);

	logic [3:0] cnt_q, cnt_n;
	logic [7:0] b0_q, b0_n, b1_q, b1_n;
	logic [wshp_pkg::AccW-1:0] acc_q, acc_n;
	logic start_byte, done;
	logic valid_s1;
	wshp_pkg::hdr_t hdr_s1;

	always_comb begin
		start_byte = header_start || (cnt_q == wshp_pkg::CNT_IDLE)
			|| (cnt_q > wshp_pkg::HDR_LEN_LONG);
		b0_n = b0_q;
		b1_n = b1_q;
		acc_n = acc_q;
		cnt_n = cnt_q;
		done = 1'b0;
		if (accept) begin
			if (start_byte) begin
				b0_n = data_byte;
				b1_n = 8'd0;
				acc_n = '0;
				cnt_n = wshp_pkg::CNT_GOT_B0;
			end else if (cnt_q == wshp_pkg::CNT_GOT_B0) begin
				b1_n = data_byte;
				acc_n = '0;
				cnt_n = cnt_q + 4'd1;
			end else begin
				acc_n = {acc_q[wshp_pkg::AccW-9:0], data_byte};
				cnt_n = cnt_q + 4'd1;
			end
			done = !start_byte && (cnt_n >= wshp_pkg::needed_bytes(b1_n));
			if (done) begin
				cnt_n = wshp_pkg::CNT_IDLE;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= wshp_pkg::CNT_IDLE;
			b0_q <= 8'd0;
			b1_q <= 8'd0;
			acc_q <= '0;
		end else begin
			cnt_q <= cnt_n;
			b0_q <= b0_n;
			b1_q <= b1_n;
			acc_q <= acc_n;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (done) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (done) begin
			hdr_s1 <= '{b0: b0_n, b1: b1_n, accum: acc_n};
		end
	end

	assign hdr_valid = valid_s1;
	assign hdr = hdr_s1;

endmodule

FILE: hdl/wshp_check.sv
// Header checks and result register: validity rules, length decode, size limit.
// Depends on wshp_pkg.
module wshp_check (
	input  logic clk,
	input  logic arst_n,
	input  logic load,
	input  wshp_pkg::hdr_t hdr,
	input  logic [wshp_pkg::PlenW-1:0] max_payload,
	input  logic take,
	output logic res_valid,
	output wshp_pkg::result_t res
);

	logic [3:0] op;
	logic [6:0] code;
	logic fin, bad;
	logic [wshp_pkg::AccW-1:0] plen;
	logic [3:0] hlen;
	wshp_pkg::result_t res_n;
	logic valid_s2;
	wshp_pkg::result_t res_s2;

	always_comb begin
		op = hdr.b0[3:0];
		code = hdr.b1[6:0];
		fin = hdr.b0[7];
		bad = (hdr.b0[6:4] != 3'd0) || hdr.b1[7]
			|| !((op <= wshp_pkg::OP_BINARY)
			|| ((op >= wshp_pkg::OP_CLOSE) && (op <= wshp_pkg::OP_PONG)));
		if (code == wshp_pkg::LEN_CODE_16) begin
			plen = {48'd0, hdr.accum[15:0]};
			hlen = wshp_pkg::HDR_LEN_MID;
			if (hdr.accum[15:0] < {9'd0, wshp_pkg::LEN_CODE_16}) begin
				bad = 1'b1;
			end
		end else if (code == wshp_pkg::LEN_CODE_64) begin
			plen = hdr.accum;
			hlen = wshp_pkg::HDR_LEN_LONG;
			// top bit set, or fits in 16 bits
			if (hdr.accum[63] || (hdr.accum[62:16] == 47'd0)) begin
				bad = 1'b1;
			end
		end else begin
			plen = {57'd0, code};
			hlen = wshp_pkg::HDR_LEN_SHORT;
		end
		if (op[3] && ((plen > {57'd0, wshp_pkg::CTRL_MAX_LEN}) || !fin)) begin
			bad = 1'b1;
		end
		if (bad) begin
			res_n = '0;
			res_n.status = wshp_pkg::ST_PROTO_ERR;
		end else begin
			res_n.status = (plen[wshp_pkg::PlenW-1:0] > max_payload) ?
				wshp_pkg::ST_TOO_LARGE : wshp_pkg::ST_OK;
			res_n.fin_flag = fin;
			res_n.frame_opcode = op;
			res_n.payload_length = plen[wshp_pkg::PlenW-1:0];
			res_n.header_length = hlen;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (load) begin
			valid_s2 <= 1'b1;
		end else if (take) begin
			valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			res_s2 <= res_n;
		end
	end

	assign res_valid = valid_s2;
	assign res = res_s2;

endmodule

FILE: hdl/websocket_header_parser_unit.sv
// Top level of the WebSocket frame header parser.
// Depends on wshp_pkg, wshp_if, wshp_capture and wshp_check.
//
// Header bytes enter on hdr, one request per cycle; the block takes one byte
// every clock as long as the result side drains. A header_start request
// restarts at byte 0. When a 2, 4 or 10 byte header completes, one result
// request leaves on res: the capture stage registers the completed header,
// then the check stage evaluates the reserved bits, opcode, mask bit, minimal
// length encoding and control-frame rules, compares the length with
// max_payload and registers the result. Both stages hold under backpressure,
// so up to two headers may be in flight while a result waits. Bytes that do
// not complete a header produce no result.
// Write max_payload (reset 4096) through cfg_wr_en/cfg_wr_data only while idle.
module websocket_header_parser_unit (
	input  logic clk,
	input  logic arst_n,
	input  logic cfg_wr_en,
	input  logic [wshp_pkg::PlenW-1:0] cfg_wr_data,
	wshp_in_if.sink hdr,
	wshp_out_if.source res
);

	logic [wshp_pkg::PlenW-1:0] max_payload_q;
	logic hdr_valid;
	wshp_pkg::hdr_t hdr_data;
	logic res_valid;
	wshp_pkg::result_t res_data;
	logic s2_load, s1_adv, accept;

	// hold the payload limit
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_payload_q <= wshp_pkg::MAX_PAYLOAD_RST;
		end else if (cfg_wr_en) begin
			max_payload_q <= cfg_wr_data;
		end
	end

	// advance the check stage when its result register is empty or being taken
	assign s2_load = !res_valid || res.ready;
	assign s1_adv = hdr_valid && s2_load;
	// accept a byte unless a completed header is stuck in the capture stage
	assign hdr.ready = !hdr_valid || s2_load;
	assign accept = hdr.valid && hdr.ready;

	wshp_capture u_capture (
		.clk(clk),
		.arst_n(arst_n),
		.accept(accept),
		.data_byte(hdr.data_byte),
		.header_start(hdr.header_start),
		.advance(s1_adv),
		.hdr_valid(hdr_valid),
		.hdr(hdr_data)
	);

	wshp_check u_check (
		.clk(clk),
		.arst_n(arst_n),
		.load(s1_adv),
		.hdr(hdr_data),
		.max_payload(max_payload_q),
		.take(res.ready),
		.res_valid(res_valid),
		.res(res_data)
	);

	assign res.valid = res_valid;
	assign res.status = res_data.status;
	assign res.fin_flag = res_data.fin_flag;
	assign res.frame_opcode = res_data.frame_opcode;
	assign res.payload_length = res_data.payload_length;
	assign res.header_length = res_data.header_length;

endmodule

FILE: hdl/wshp_checker.sv
// Port-level assertions for the header parser, bound to the top level.
// Depends on wshp_pkg and websocket_header_parser_unit.
module wshp_checker (
	input  logic clk,
	input  logic arst_n,
	input  logic res_valid,
	input  logic res_ready,
	input  logic [1:0] status,
	input  logic fin_flag,
	input  logic [3:0] frame_opcode,
	input  logic [wshp_pkg::PlenW-1:0] payload_length,
	input  logic [3:0] header_length
);

	// hold a stalled result request
	a_res_hold: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !res_ready |=> res_valid && $stable(status)
			&& $stable(payload_length))
		else $error("result request dropped or changed while stalled");

	a_err_zero: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && (status == wshp_pkg::ST_PROTO_ERR) |->
			!fin_flag && (frame_opcode == 4'd0) && (payload_length == '0)
			&& (header_length == 4'd0))
		else $error("protocol error result carries nonzero fields");

	a_hlen: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && (status != wshp_pkg::ST_PROTO_ERR) |->
			(header_length == wshp_pkg::HDR_LEN_SHORT)
			|| (header_length == wshp_pkg::HDR_LEN_MID)
			|| (header_length == wshp_pkg::HDR_LEN_LONG))
		else $error("bad header length on accepted header");

	a_ctrl: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && (status != wshp_pkg::ST_PROTO_ERR) && frame_opcode[3] |->
			fin_flag && (payload_length <= 63'd125))
		else $error("control frame passed with long payload or no fin");

endmodule

bind websocket_header_parser_unit wshp_checker u_wshp_checker (
	.clk(clk),
	.arst_n(arst_n),
	.res_valid(res.valid),
	.res_ready(res.ready),
	.status(res.status),
	.fin_flag(res.fin_flag),
	.frame_opcode(res.frame_opcode),
	.payload_length(res.payload_length),
	.header_length(res.header_length)
);

FILE: verif/testbench.sv
`timescale 1ns / 1ps
// Self-checking bench for websocket_header_parser_unit: sends header byte requests,
// predicts each parse result and compares it field by field on the result channel.
// Depends on wshp_pkg and the wshp_in_if / wshp_out_if interfaces.
module testbench;
	import wshp_pkg::*;

	// opcodes that the package does not name
	localparam logic [3:0] OP_CONT = 4'h0;
	localparam logic [3:0] OP_TEXT = 4'h1;
	localparam logic [3:0] OP_RSV_DATA = 4'h3;
	localparam logic [3:0] OP_PING = 4'h9;
	localparam logic [3:0] OP_RSV_CTRL = 4'hB;
	localparam logic [3:0] OP_RSV_TOP = 4'hF;

	localparam logic [AccW-1:0] LONG_LEN_MIN = 64'h1_0000;
	localparam logic [PlenW-1:0] PLEN_MAX = {PlenW{1'b1}};
	localparam int DRAIN_CYCLES = 8;
	localparam int RANDOM_BYTES = 730;
	localparam int PHASE_BYTES = 150;

	logic clk;
	logic arst_n;
	logic cfg_wr_en;
	logic [PlenW-1:0] cfg_wr_data;

	wshp_in_if hdr_ch();
	wshp_out_if res_ch();

	websocket_header_parser_unit dut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_wr_en(cfg_wr_en),
		.cfg_wr_data(cfg_wr_data),
		.hdr(hdr_ch),
		.res(res_ch)
	);

	// parser state as the bench sees it
	logic [3:0] hdr_count;
	logic [7:0] hdr_b0;
	logic [7:0] hdr_b1;
	logic [AccW-1:0] hdr_accum;
	logic [PlenW-1:0] max_payload;

	// parse results owed by the block, oldest first
	result_t verdicts_due[$];

	int unsigned mismatch_count = 0;
	int unsigned bytes_sent = 0;
	bit src_gaps_on = 1'b1;
	bit sink_stalls_on = 1'b1;
	int unsigned stall_left = 0;

	initial clk = 1'b0;
	always #10 clk = ~clk;

	// mostly short pauses, now and then a long one
	function automatic int unsigned pick_gap();
		int unsigned r;
		r = $urandom_range(0, 99);
		if (r < 55) begin
			return 0;
		end else if (r < 85) begin
			return $urandom_range(1, 3);
		end else if (r < 97) begin
			return $urandom_range(4, 10);
		end
		return $urandom_range(20, 60);
	endfunction

	function automatic logic [7:0] lead_byte(input logic fin, input logic [3:0] op);
		return {fin, 3'b000, op};
	endfunction

	function automatic logic [7:0] len_byte(input logic mask, input logic [6:0] code);
		return {mask, code};
	endfunction

	// Evaluate the header held in the predictor state once its last byte is in.
	function automatic result_t judge_header();
		result_t v;
		logic [3:0] op;
		logic [6:0] code;
		logic fin;
		logic bad;
		logic [AccW-1:0] plen;
		logic [3:0] hlen;
		op = hdr_b0[3:0];
		code = hdr_b1[6:0];
		fin = hdr_b0[7];
		bad = (hdr_b0[6:4] != 3'b000) || hdr_b1[7];
		if (!(op <= OP_BINARY || (op >= OP_CLOSE && op <= OP_PONG))) begin
			bad = 1'b1;
		end
		if (code == LEN_CODE_16) begin
			plen = {48'd0, hdr_accum[15:0]};
			hlen = HDR_LEN_MID;
			if (plen < LEN_CODE_16) begin
				bad = 1'b1;
			end
		end else if (code == LEN_CODE_64) begin
			plen = hdr_accum;
			hlen = HDR_LEN_LONG;
			if (plen[AccW-1] || plen < LONG_LEN_MIN) begin
				bad = 1'b1;
			end
		end else begin
			plen = {57'd0, code};
			hlen = HDR_LEN_SHORT;
		end
		// control frames: short and unfragmented only
		if (op[3] && (plen > CTRL_MAX_LEN || !fin)) begin
			bad = 1'b1;
		end
		v = '0;
		if (bad) begin
			v.status = ST_PROTO_ERR;
		end else begin
			if (plen[PlenW-1:0] > max_payload) begin
				v.status = ST_TOO_LARGE;
			end else begin
				v.status = ST_OK;
			end
			v.fin_flag = fin;
			v.frame_opcode = op;
			v.payload_length = plen[PlenW-1:0];
			v.header_length = hlen;
		end
		return v;
	endfunction

	// Advance the predictor by one accepted byte; queue a result on completion.
	function automatic void take_byte(input logic [7:0] b, input logic mark);
		logic [3:0] need;
		if (mark || hdr_count == CNT_IDLE || hdr_count > HDR_LEN_LONG) begin
			hdr_b0 = b;
			hdr_b1 = 8'd0;
			hdr_accum = '0;
			hdr_count = CNT_GOT_B0;
			return;
		end
		if (hdr_count == CNT_GOT_B0) begin
			hdr_b1 = b;
			hdr_accum = '0;
		end else begin
			hdr_accum = {hdr_accum[AccW-9:0], b};
		end
		hdr_count = hdr_count + 4'd1;
		if (hdr_b1[6:0] == LEN_CODE_16) begin
			need = HDR_LEN_MID;
		end else if (hdr_b1[6:0] == LEN_CODE_64) begin
			need = HDR_LEN_LONG;
		end else begin
			need = HDR_LEN_SHORT;
		end
		if (hdr_count >= need) begin
			verdicts_due.push_back(judge_header());
			hdr_count = CNT_IDLE;
		end
	endfunction

	// Send one byte request. Enter and leave on a falling edge; valid stays high
	// on exit so back-to-back requests need no second assignment in one step.
	task automatic send_byte(input logic [7:0] b, input logic mark);
		int unsigned gap;
		gap = src_gaps_on ? pick_gap() : 0;
		if (gap != 0) begin
			hdr_ch.valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		hdr_ch.valid <= 1'b1;
		hdr_ch.data_byte <= b;
		hdr_ch.header_start <= mark;
		do @(posedge clk); while (!hdr_ch.ready);
		take_byte(b, mark);
		bytes_sent++;
		@(negedge clk);
	endtask

	// Send a whole header; the length code in b1 decides how many length bytes follow.
	task automatic send_header(input logic [7:0] b0, input logic [7:0] b1,
			input logic [AccW-1:0] ext, input logic mark);
		int n;
		if (b1[6:0] == LEN_CODE_16) begin
			n = 2;
		end else if (b1[6:0] == LEN_CODE_64) begin
			n = 8;
		end else begin
			n = 0;
		end
		send_byte(b0, mark);
		send_byte(b1, 1'b0);
		for (int i = n - 1; i >= 0; i--) begin
			send_byte(ext[8*i +: 8], 1'b0);
		end
	endtask

	// Drop valid, drain the result pipe, then write the limit.
	task automatic write_max_payload(input logic [PlenW-1:0] limit);
		hdr_ch.valid <= 1'b0;
		while (verdicts_due.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(negedge clk);
		cfg_wr_en <= 1'b1;
		cfg_wr_data <= limit;
		@(negedge clk);
		cfg_wr_en <= 1'b0;
		max_payload = limit;
	endtask

	// Hold ready low for a random stall now and then.
	always @(negedge clk) begin
		if (stall_left != 0) begin
			res_ch.ready <= 1'b0;
			stall_left--;
		end else begin
			res_ch.ready <= 1'b1;
			if (sink_stalls_on && $urandom_range(0, 3) == 0) begin
				stall_left = pick_gap();
			end
		end
	end

	// Compare every accepted result request with the oldest prediction.
	always @(posedge clk) begin : check_results
		result_t want;
		if (arst_n && res_ch.valid && res_ch.ready) begin
			if (verdicts_due.size() == 0) begin
				$error("result with none expected: status %0d length %0d",
					res_ch.status, res_ch.payload_length);
				mismatch_count++;
			end else begin
				want = verdicts_due.pop_front();
				if (res_ch.status !== want.status) begin
					$error("status: expected %0d, got %0d", want.status, res_ch.status);
					mismatch_count++;
				end
				if (res_ch.fin_flag !== want.fin_flag) begin
					$error("fin_flag: expected %0d, got %0d", want.fin_flag,
						res_ch.fin_flag);
					mismatch_count++;
				end
				if (res_ch.frame_opcode !== want.frame_opcode) begin
					$error("frame_opcode: expected %0h, got %0h", want.frame_opcode,
						res_ch.frame_opcode);
					mismatch_count++;
				end
				if (res_ch.payload_length !== want.payload_length) begin
					$error("payload_length: expected %0h, got %0h", want.payload_length,
						res_ch.payload_length);
					mismatch_count++;
				end
				if (res_ch.header_length !== want.header_length) begin
					$error("header_length: expected %0d, got %0d", want.header_length,
						res_ch.header_length);
					mismatch_count++;
				end
			end
		end
	end

	// Plain data frames, short and 16-bit lengths, one byte 0 without start mark.
	task automatic test_data_frames();
		send_header(lead_byte(1'b1, OP_TEXT), len_byte(1'b0, 7'd0), '0, 1'b1);
		send_header(lead_byte(1'b1, OP_BINARY), len_byte(1'b0, CTRL_MAX_LEN), '0, 1'b1);
		// idle parser takes byte 0 even with the start mark clear
		send_header(lead_byte(1'b0, OP_CONT), len_byte(1'b0, 7'd5), '0, 1'b0);
		send_header(lead_byte(1'b1, OP_TEXT), len_byte(1'b0, LEN_CODE_16), 64'd126, 1'b1);
		send_header(lead_byte(1'b1, OP_BINARY), len_byte(1'b0, LEN_CODE_16), 64'hFFFF, 1'b1);
	endtask

	task automatic test_control_frames();
		send_header(lead_byte(1'b1, OP_CLOSE), len_byte(1'b0, 7'd0), '0, 1'b1);
		send_header(lead_byte(1'b1, OP_PING), len_byte(1'b0, CTRL_MAX_LEN), '0, 1'b1);
		send_header(lead_byte(1'b1, OP_PONG), len_byte(1'b0, 7'd7), '0, 1'b1);
		// fragmented control frame, then one too long for a control frame
		send_header(lead_byte(1'b0, OP_PING), len_byte(1'b0, 7'd3), '0, 1'b1);
		send_header(lead_byte(1'b1, OP_CLOSE), len_byte(1'b0, LEN_CODE_16), 64'd126, 1'b1);
	endtask

	task automatic test_protocol_errors();
		send_header(8'hF1, len_byte(1'b0, 7'd1), '0, 1'b1);
		send_header(lead_byte(1'b1, OP_RSV_DATA), len_byte(1'b0, 7'd1), '0, 1'b1);
		send_header(lead_byte(1'b1, OP_RSV_CTRL), len_byte(1'b0, 7'd1), '0, 1'b1);
		send_header(lead_byte(1'b1, OP_RSV_TOP), len_byte(1'b0, 7'd1), '0, 1'b1);
		send_header(lead_byte(1'b1, OP_TEXT), len_byte(1'b1, 7'd5), '0, 1'b1);
		// non-minimal 16-bit lengths
		send_header(lead_byte(1'b1, OP_TEXT), len_byte(1'b0, LEN_CODE_16), 64'd125, 1'b1);
		send_header(lead_byte(1'b1, OP_TEXT), len_byte(1'b0, LEN_CODE_16), 64'd0, 1'b1);
	endtask

	task automatic test_extended_lengths();
		send_header(lead_byte(1'b1, OP_BINARY), len_byte(1'b0, LEN_CODE_16), 64'd4096, 1'b1);
		send_header(lead_byte(1'b1, OP_BINARY), len_byte(1'b0, LEN_CODE_16), 64'd4097, 1'b1);
		send_header(lead_byte(1'b1, OP_BINARY), len_byte(1'b0, LEN_CODE_64), LONG_LEN_MIN,
			1'b1);
		// non-minimal 64-bit length, top bit set, largest legal length
		send_header(lead_byte(1'b1, OP_BINARY), len_byte(1'b0, LEN_CODE_64), 64'hFFFF, 1'b1);
		send_header(lead_byte(1'b1, OP_TEXT), len_byte(1'b0, LEN_CODE_64), '1, 1'b1);
		send_header(lead_byte(1'b1, OP_TEXT), len_byte(1'b0, LEN_CODE_64),
			{1'b0, PLEN_MAX}, 1'b1);
	endtask

	// A start mark in the middle of a header drops the partial one.
	task automatic test_resync();
		send_byte(lead_byte(1'b1, OP_TEXT), 1'b1);
		send_byte(len_byte(1'b0, LEN_CODE_16), 1'b0);
		send_byte(8'h12, 1'b0);
		send_header(lead_byte(1'b1, OP_BINARY), len_byte(1'b0, 7'd9), '0, 1'b1);
		send_byte(lead_byte(1'b1, OP_CLOSE), 1'b1);
		send_header(lead_byte(1'b1, OP_PONG), len_byte(1'b0, 7'd2), '0, 1'b1);
	endtask

	task automatic test_max_payload();
		write_max_payload('0);
		send_header(lead_byte(1'b1, OP_TEXT), len_byte(1'b0, 7'd0), '0, 1'b1);
		send_header(lead_byte(1'b1, OP_TEXT), len_byte(1'b0, 7'd1), '0, 1'b1);
		write_max_payload(PLEN_MAX);
		send_header(lead_byte(1'b1, OP_BINARY), len_byte(1'b0, LEN_CODE_64),
			{1'b0, PLEN_MAX}, 1'b1);
		write_max_payload(63'd125);
		send_header(lead_byte(1'b1, OP_TEXT), len_byte(1'b0, CTRL_MAX_LEN), '0, 1'b1);
		send_header(lead_byte(1'b1, OP_TEXT), len_byte(1'b0, LEN_CODE_16), 64'd126, 1'b1);
		write_max_payload(PlenW'({$urandom, $urandom}));
		write_max_payload(MAX_PAYLOAD_RST);
	endtask

	function automatic logic [PlenW-1:0] pick_limit();
		case ($urandom_range(0, 5))
			0: return PlenW'($urandom_range(0, 200));
			1: return PlenW'($urandom_range(0, 70000));
			2: return PlenW'({$urandom, $urandom});
			3: return PLEN_MAX;
			4: return MAX_PAYLOAD_RST;
			default: return PlenW'($urandom_range(0, 65535));
		endcase
	endfunction

	// One well-formed header with random content, mostly legal.
	task automatic send_random_header();
		logic fin;
		logic [3:0] op;
		logic [7:0] b0;
		logic [6:0] code;
		logic [AccW-1:0] ext;
		int unsigned k;
		fin = $urandom_range(0, 3) != 0;
		case ($urandom_range(0, 9))
			0: op = OP_CONT;
			1, 2: op = OP_TEXT;
			3, 4: op = OP_BINARY;
			5: op = OP_CLOSE;
			6: op = OP_PING;
			7: op = OP_PONG;
			default: op = 4'($urandom_range(0, 15));
		endcase
		b0 = lead_byte(fin, op);
		if ($urandom_range(0, 19) == 0) begin
			b0[6:4] = 3'($urandom_range(1, 7));
		end
		k = $urandom_range(0, 9);
		if (op[3] && $urandom_range(0, 9) != 0) begin
			k = 0;
		end
		ext = {$urandom, $urandom};
		if (k < 5) begin
			code = 7'($urandom_range(0, 125));
		end else if (k < 8) begin
			code = LEN_CODE_16;
			if ($urandom_range(0, 7) == 0) begin
				ext[15:0] = 16'($urandom_range(0, 125));
			end else if ($urandom_range(0, 3) == 0) begin
				ext[15:0] = max_payload[15:0] + 16'($urandom_range(0, 2)) - 16'd1;
			end
		end else begin
			code = LEN_CODE_64;
			case ($urandom_range(0, 5))
				0: ext = 64'($urandom_range(0, 65535));
				1: ext = {1'b1, ext[AccW-2:0]};
				2: ext = {1'b0, max_payload} + 64'($urandom_range(0, 2)) - 64'd1;
				3: ext = {1'b0, ext[AccW-2:0]};
				default: ext = {1'b0, ext[AccW-2:0]} >> $urandom_range(0, 46);
			endcase
		end
		send_header(b0, len_byte($urandom_range(0, 19) == 0, code), ext,
			$urandom_range(0, 7) != 0);
	endtask

	// Mostly whole headers; the rest truncated headers and loose bytes.
	task automatic test_random_stream();
		int unsigned run_start;
		int unsigned phase_start;
		int unsigned phase;
		int unsigned r;
		int unsigned cut;
		run_start = bytes_sent;
		phase = 0;
		while (bytes_sent - run_start < RANDOM_BYTES) begin
			case (phase)
				0: begin
					src_gaps_on = 1'b1;
					sink_stalls_on = 1'b1;
				end
				1: begin
					src_gaps_on = 1'b0;
					sink_stalls_on = 1'b0;
				end
				default: begin
					src_gaps_on = $urandom_range(0, 2) != 0;
					sink_stalls_on = $urandom_range(0, 2) != 0;
				end
			endcase
			write_max_payload(pick_limit());
			phase_start = bytes_sent;
			while (bytes_sent - phase_start < PHASE_BYTES
					&& bytes_sent - run_start < RANDOM_BYTES) begin
				r = $urandom_range(0, 99);
				if (r < 80) begin
					send_random_header();
				end else if (r < 90) begin
					send_byte(8'($urandom), 1'b1);
					send_byte(len_byte(1'($urandom_range(0, 1)),
						$urandom_range(0, 1) ? LEN_CODE_16 : LEN_CODE_64), 1'b0);
					cut = $urandom_range(0, 1);
					repeat (cut) send_byte(8'($urandom), 1'b0);
				end else begin
					send_byte(8'($urandom), 1'($urandom_range(0, 1)));
				end
			end
			phase++;
		end
	endtask

	initial begin
		arst_n = 1'b0;
		cfg_wr_en = 1'b0;
		cfg_wr_data = '0;
		hdr_ch.valid = 1'b0;
		hdr_ch.data_byte = 8'd0;
		hdr_ch.header_start = 1'b0;
		res_ch.ready = 1'b0;
		hdr_count = CNT_IDLE;
		hdr_b0 = 8'd0;
		hdr_b1 = 8'd0;
		hdr_accum = '0;
		max_payload = MAX_PAYLOAD_RST;
		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		test_data_frames();
		test_control_frames();
		test_protocol_errors();
		test_extended_lengths();
		test_resync();
		test_max_payload();
		test_random_stream();

		// drop valid and let the pipe drain
		hdr_ch.valid <= 1'b0;
		while (verdicts_due.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (mismatch_count == 0) begin
			$display("end of test: clean");
		end else begin
			$display("end of test: mismatches");
		end
		$finish;
	end

	// hard stop well beyond the slowest legal run
	initial begin
		#20_000_000;
		$display("end of test: mismatches");
		$finish;
	end

endmodule
